>>> rtl/pfa_pkg.sv
`default_nettype none
package pfa_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_DIGITS = 32;
   localparam int DEF_FRAC_BITS  = 32;

   // Fixed field widths
   localparam int DATA_W   = 32;
   localparam int BASE_W   = 8;
   localparam int COUNT_W  = 6;
   localparam int CNT_EFF_W = 7;
   localparam int ADDR_W   = 3;

   // Quotient bits resolved per Horner pipeline stage
   localparam int DIV_STEP = 8;

   // Register reset values
   localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd2;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   // Register indexes
   typedef enum logic [0:0] {
      REG_DIGIT_BASE  = 1'b0,
      REG_DIGIT_COUNT = 1'b1
   } reg_index_type;

   // Radix below two is treated as two
   function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] p);
      eff_base = (p < BASE_W'(2)) ? BASE_W'(2) : p;
   endfunction

endpackage
`default_nettype wire

>>> rtl/padic_fraction_adder.sv
// Channel  | Dir | Handshake         | Beat
// req      | in  | req_valid/stall   | first_fraction, second_fraction
// rsp      | out | rsp_valid/stall   | sum_fraction
// csr      | in  | psel/penable/...  | digit_base (0x0), digit_count (0x4)
//
// One beat per cycle while the result is not stalled; the pipeline is
// one expansion stage per digit and one Horner digit per digit, split in
// stages of eight quotient bits each.
// Synchronous active-high reset clears the valid bits and the registers.
// A stalled result freezes the whole pipeline; req_stall follows it.
`default_nettype none
module padic_fraction_adder import pfa_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [DATA_W-1:0] req_first_fraction,
   input  wire logic [DATA_W-1:0] req_second_fraction,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DATA_W-1:0]      rsp_sum_fraction,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   logic [BASE_W-1:0]   digit_base_ff;
   logic [COUNT_W-1:0]  digit_count_ff;
   logic [BASE_W-1:0]   base_eff;
   logic [CNT_EFF_W-1:0] count_eff;
   reg_index_type       reg_idx;
   logic                en;

   // Configuration registers
   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_base_ff  <= BASE_RESET;
         digit_count_ff <= COUNT_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_DIGIT_BASE:  digit_base_ff  <= pwdata[BASE_W-1:0];
            REG_DIGIT_COUNT: digit_count_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DIGIT_BASE:  prdata = DATA_W'(digit_base_ff);
         REG_DIGIT_COUNT: prdata = DATA_W'(digit_count_ff);
         default:         prdata = '0;
      endcase
   end

   assign base_eff  = eff_base(digit_base_ff);
   assign count_eff = (CNT_EFF_W'(digit_count_ff) > CNT_EFF_W'(MAX_DIGITS))
                    ? CNT_EFF_W'(MAX_DIGITS) : CNT_EFF_W'(digit_count_ff);

   // Pipeline advances unless the result register is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Operand conversion to Q0.FRAC_BITS
   logic [DATA_W+FRAC_BITS-1:0] wide_a, wide_b;
   assign wide_a = {req_first_fraction,  {FRAC_BITS{1'b0}}};
   assign wide_b = {req_second_fraction, {FRAC_BITS{1'b0}}};

   // Digit expansion chain, most significant digit first
   logic                              ex_valid  [MAX_DIGITS+1];
   logic [FRAC_BITS-1:0]              ex_a      [MAX_DIGITS+1];
   logic [FRAC_BITS-1:0]              ex_b      [MAX_DIGITS+1];
   logic                              ex_carry  [MAX_DIGITS+1];
   logic [MAX_DIGITS-1:0][BASE_W-1:0] ex_digits [MAX_DIGITS+1];

   assign ex_valid[0]  = req_valid;
   assign ex_a[0]      = wide_a[DATA_W+FRAC_BITS-1:DATA_W];
   assign ex_b[0]      = wide_b[DATA_W+FRAC_BITS-1:DATA_W];
   assign ex_carry[0]  = 1'b0;
   assign ex_digits[0] = '0;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_expand
      pfa_expand_stage #(
         .FRAC_BITS(FRAC_BITS), .MAX_DIGITS(MAX_DIGITS), .DIG(i)
      ) u_expand (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(ex_valid[i]), .in_a(ex_a[i]), .in_b(ex_b[i]),
         .in_carry(ex_carry[i]), .in_digits(ex_digits[i]),
         .base(base_eff), .count(count_eff),
         .out_valid(ex_valid[i+1]), .out_a(ex_a[i+1]), .out_b(ex_b[i+1]),
         .out_carry(ex_carry[i+1]), .out_digits(ex_digits[i+1])
      );
   end

   // Horner rebuild, least significant digit first
   logic                              hr_valid  [MAX_DIGITS+1];
   logic [FRAC_BITS-1:0]              hr_r      [MAX_DIGITS+1];
   logic [MAX_DIGITS-1:0][BASE_W-1:0] hr_digits [MAX_DIGITS+1];

   assign hr_valid[0]  = ex_valid[MAX_DIGITS];
   assign hr_r[0]      = '0;
   assign hr_digits[0] = ex_digits[MAX_DIGITS];

   for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_horner
      pfa_horner_digit #(
         .FRAC_BITS(FRAC_BITS), .MAX_DIGITS(MAX_DIGITS), .DIG(MAX_DIGITS-1-j)
      ) u_horner (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(hr_valid[j]), .in_r(hr_r[j]), .in_digits(hr_digits[j]),
         .base(base_eff),
         .out_valid(hr_valid[j+1]), .out_r(hr_r[j+1]), .out_digits(hr_digits[j+1])
      );
   end

   // Result back to Q0.32
   logic [FRAC_BITS+DATA_W-1:0] wide_r;
   assign wide_r           = {hr_r[MAX_DIGITS], {DATA_W{1'b0}}};
   assign rsp_valid        = hr_valid[MAX_DIGITS];
   assign rsp_sum_fraction = wide_r[FRAC_BITS+DATA_W-1:FRAC_BITS];

`ifndef SYNTHESIS
   a_base_min: assert property (@(posedge clock) disable iff (reset)
      base_eff >= BASE_W'(2))
      else $error("effective radix below two");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_eff <= CNT_EFF_W'(MAX_DIGITS))
      else $error("effective digit count above limit");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_fraction))
      else $error("held result changed");

   a_in_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while pipeline frozen");
`endif

endmodule
`default_nettype wire

>>> rtl/pfa_expand_stage.sv
`default_nettype none
module pfa_expand_stage import pfa_pkg::*; #(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int DIG        = 0
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic [FRAC_BITS-1:0]                 in_a,
   input  wire logic [FRAC_BITS-1:0]                 in_b,
   input  wire logic                                 in_carry,
   input  wire logic [MAX_DIGITS-1:0][BASE_W-1:0]    in_digits,
   input  wire logic [BASE_W-1:0]                    base,
   input  wire logic [CNT_EFF_W-1:0]                 count,
   output logic                                      out_valid,
   output logic [FRAC_BITS-1:0]                      out_a,
   output logic [FRAC_BITS-1:0]                      out_b,
   output logic                                      out_carry,
   output logic [MAX_DIGITS-1:0][BASE_W-1:0]         out_digits
);

   logic                                   valid_ff;
   logic [FRAC_BITS-1:0]                   a_ff, a_in;
   logic [FRAC_BITS-1:0]                   b_ff, b_in;
   logic                                   carry_ff, carry_in;
   logic [MAX_DIGITS-1:0][BASE_W-1:0]      digits_ff, digits_in;
   logic [FRAC_BITS+BASE_W-1:0]            prod_a, prod_b;
   logic [BASE_W:0]                        sum;

   // One digit of each operand, then add with carry modulo p
   always_comb begin
      prod_a    = (FRAC_BITS+BASE_W)'(in_a) * (FRAC_BITS+BASE_W)'(base);
      prod_b    = (FRAC_BITS+BASE_W)'(in_b) * (FRAC_BITS+BASE_W)'(base);
      a_in      = prod_a[FRAC_BITS-1:0];
      b_in      = prod_b[FRAC_BITS-1:0];
      sum       = (BASE_W+1)'(prod_a[FRAC_BITS+BASE_W-1:FRAC_BITS])
                + (BASE_W+1)'(prod_b[FRAC_BITS+BASE_W-1:FRAC_BITS])
                + (BASE_W+1)'(in_carry);
      digits_in = in_digits;
      carry_in  = 1'b0;
      if (sum >= (BASE_W+1)'(base)) begin
         sum      = sum - (BASE_W+1)'(base);
         carry_in = 1'b1;
      end
      // digits past the count stay zero so Horner passes them through
      if (CNT_EFF_W'(DIG) < count) begin
         digits_in[DIG] = sum[BASE_W-1:0];
      end else begin
         digits_in[DIG] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         carry_ff  <= carry_in;
         digits_ff <= digits_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_a      = a_ff;
   assign out_b      = b_ff;
   assign out_carry  = carry_ff;
   assign out_digits = digits_ff;

endmodule
`default_nettype wire

>>> rtl/pfa_horner_digit.sv
`default_nettype none
module pfa_horner_digit import pfa_pkg::*; #(
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int DIG        = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [FRAC_BITS-1:0]              in_r,
   input  wire logic [MAX_DIGITS-1:0][BASE_W-1:0] in_digits,
   input  wire logic [BASE_W-1:0]                 base,
   output logic                                   out_valid,
   output logic [FRAC_BITS-1:0]                   out_r,
   output logic [MAX_DIGITS-1:0][BASE_W-1:0]      out_digits
);

   // r = floor((r + d * 2^F) / p): restoring division, remainder seeded with d
   localparam int SUB = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;

   logic                                  valid_ff  [SUB];
   logic [BASE_W-1:0]                     rem_ff    [SUB];
   logic [FRAC_BITS-1:0]                  wrk_ff    [SUB];
   logic [MAX_DIGITS-1:0][BASE_W-1:0]     digits_ff [SUB];

   for (genvar k = 0; k < SUB; k++) begin : g_sub
      localparam int STEPS = (k == SUB - 1) ? FRAC_BITS - DIV_STEP * (SUB - 1) : DIV_STEP;

      logic                              vld_src;
      logic [BASE_W-1:0]                 rem_src;
      logic [FRAC_BITS-1:0]              wrk_src;
      logic [MAX_DIGITS-1:0][BASE_W-1:0] dig_src;
      logic [BASE_W-1:0]                 rem_in;
      logic [FRAC_BITS-1:0]              wrk_in;
      logic [BASE_W:0]                   trial;

      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = in_digits[DIG];
         assign wrk_src = in_r;
         assign dig_src = in_digits;
      end else begin : g_next
         assign vld_src = valid_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign wrk_src = wrk_ff[k-1];
         assign dig_src = digits_ff[k-1];
      end

      // STEPS quotient bits, shifted in at the bottom of the work word
      always_comb begin
         rem_in = rem_src;
         wrk_in = wrk_src;
         trial  = '0;
         for (int s = 0; s < STEPS; s++) begin
            trial  = {rem_in, wrk_in[FRAC_BITS-1]};
            wrk_in = {wrk_in[FRAC_BITS-2:0], 1'b0};
            if (trial >= (BASE_W+1)'(base)) begin
               trial     = trial - (BASE_W+1)'(base);
               wrk_in[0] = 1'b1;
            end
            rem_in = trial[BASE_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]    <= rem_in;
            wrk_ff[k]    <= wrk_in;
            digits_ff[k] <= dig_src;
         end
      end
   end

   assign out_valid  = valid_ff[SUB-1];
   assign out_r      = wrk_ff[SUB-1];
   assign out_digits = digits_ff[SUB-1];

endmodule
`default_nettype wire

>>> dv/padic_fraction_adder_test.sv
`default_nettype none
module padic_fraction_adder_test;
   import pfa_pkg::*;

   localparam int LATENCY   = 160;
   localparam int LIMIT     = 1000000;
   localparam int N_RANDOM  = 1700;

   // Scoreboard: predicts each p-adic sum and checks results in order
   class padic_sum_board;
      bit [BASE_W-1:0]  base_reg;
      bit [COUNT_W-1:0] count_reg;
      bit [DATA_W-1:0]  sum_queue[$];
      int errors;

      function new();
         base_reg  = BASE_RESET;
         count_reg = COUNT_RESET;
         errors    = 0;
      endfunction

      function bit [DATA_W-1:0] padic_sum(bit [DATA_W-1:0] a, bit [DATA_W-1:0] b);
         bit [63:0] fa, fb, ta, tb, r;
         int p, n, carry, s, i;
         int da[32], db[32], ds[32];
         p = (base_reg < 2) ? 2 : base_reg;
         n = (count_reg > 32) ? 32 : count_reg;
         fa = a;
         fb = b;
         for (i = 0; i < n; i++) begin
            ta = fa * p;
            tb = fb * p;
            da[i] = ta[63:32];
            db[i] = tb[63:32];
            fa = {32'd0, ta[31:0]};
            fb = {32'd0, tb[31:0]};
         end
         carry = 0;
         for (i = 0; i < n; i++) begin
            s = carry + da[i] + db[i];
            ds[i] = s % p;
            carry = s / p;
         end
         r = 0;
         for (i = n; i > 0; i--)
            r = (r + (64'(ds[i-1]) << 32)) / 64'(p);
         return r[31:0];
      endfunction

      function void note_input(bit [DATA_W-1:0] a, bit [DATA_W-1:0] b);
         sum_queue = {sum_queue, padic_sum(a, b)};
      endfunction

      // One line per mismatch, counted here
      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_result(bit [DATA_W-1:0] got);
         bit [DATA_W-1:0] want;
         if (sum_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         want = sum_queue.pop_front();
         if (got !== want)
            report_mismatch($sformatf("sum_fraction got %h want %h", got, want));
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [DATA_W-1:0] req_first_fraction = 0;
   logic [DATA_W-1:0] req_second_fraction = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [DATA_W-1:0] rsp_sum_fraction;
   logic              psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [DATA_W-1:0] pwdata = 0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   padic_sum_board board;
   int  cycle = 0;
   bit  long_hold = 0;

   padic_fraction_adder DUT (.*);

   always #5 clock = ~clock;

   // Cycle limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Register write, only while idle
   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] val);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= ADDR_W'(4 * idx);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      if (idx == REG_DIGIT_BASE) board.base_reg = val[BASE_W-1:0];
      else board.count_reg = val[COUNT_W-1:0];
   endtask

   // Send one beat, with a random gap before it
   task automatic send_beat(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      int gap;
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(10);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1;
      req_first_fraction  <= a;
      req_second_fraction <= b;
      do @(posedge clock); while (req_stall);
      board.note_input(a, b);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.sum_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] rand_frac();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Result receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_sum_fraction);
   end

   initial begin : receiver
      int wait_n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (LATENCY * 3) @(posedge clock);
            long_hold = 0;
         end
         wait_n = $urandom_range(2) == 0 ? 0 : $urandom_range(10);
         if (wait_n > 0) begin
            rsp_stall <= 1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int i, ph;
      int bases[6]  = '{2, 3, 255, 0, 1, 7};
      int counts[6] = '{32, 1, 63, 0, 17, 5};
      board = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset settings, field extremes
      send_beat(32'h0, 32'h0);
      send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(32'h8000_0000, 32'h8000_0000);
      send_beat(32'h0000_0001, 32'hFFFF_FFFF);
      drain();
      // Base below two, count zero, count above limit, extremes
      for (ph = 0; ph < 6; ph++) begin
         write_reg(REG_DIGIT_BASE, bases[ph]);
         write_reg(REG_DIGIT_COUNT, counts[ph]);
         send_beat(32'hFFFF_FFFF, 32'h0000_0001);
         send_beat(32'h5555_5555, 32'hAAAA_AAAA);
         send_beat(32'h0, 32'hFFFF_FFFF);
         drain();
      end

      // Random phases, several settings
      for (ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            write_reg(REG_DIGIT_BASE, 255);
            write_reg(REG_DIGIT_COUNT, 32);
         end else begin
            write_reg(REG_DIGIT_BASE, $urandom_range(255));
            write_reg(REG_DIGIT_COUNT, $urandom_range(63));
         end
         if (ph == 3) long_hold = 1;
         for (i = 0; i < N_RANDOM / 8; i++)
            send_beat(rand_frac(), rand_frac());
         drain();
      end

      if (board.errors == 0 && board.sum_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
